// ===== design/arpc_pkg.sv =====
// Package for the ARP cache table: command codes, the token that travels
// along the row of entry cells, and shared constants. No dependencies.
package arpc_pkg;

  localparam int ENTRIES_DEF    = 128;
  localparam int IP_W           = 32;
  localparam int MAC_W          = 48;
  localparam int SEC_W          = 32;
  localparam int TMO_W          = 16;
  localparam int CMD_W          = 2;
  localparam int IN_DATA_W      = 80;
  localparam int OUT_DATA_W     = 56;
  localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd15;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_TICK   = 2'd2
  } arpc_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } arpc_state_t;

  typedef struct packed {
    logic             vld;
    arpc_cmd_t        cmd;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    logic [SEC_W-1:0] secs;
    logic             hit;
    logic             pend;
  } arpc_tok_t;

  typedef struct packed {
    logic             stored;
    logic [MAC_W-1:0] mac;
    logic             hit;
  } arpc_res_t;

endpackage

// ===== design/arp_cache_table.sv =====
// IPv4-to-MAC cache with aging: a row of ENTRIES cells is walked by each
// item as a token moving one cell per cycle. As the token leaves the last
// cell its result is registered, and in_tready rises in that same cycle,
// so a new item is taken only once the last one has left the cell row.
// While a result waits unread in the output register, one more item may
// complete into a holding register, after which the input stalls (in_tready
// stays low) until the output drains. A lookup returns the MAC of the
// highest-indexed valid match, an insert fills the lowest free slot (stored
// is 0 when the table is full), and a tick advances the seconds counter and
// drops entries older than the timeout. Every item yields exactly one
// result. Depends on arpc_pkg and arpc_cell.
module arp_cache_table #(
  parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // ip_addr[31:0], mac_addr[79:32]
  input  logic [arpc_pkg::IN_DATA_W-1:0]  in_tdata,
  // command[1:0]
  input  logic [arpc_pkg::CMD_W-1:0]      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // hit[0], mac_out[48:1], stored[49], zero[55:50]
  output logic [arpc_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_wr_en,
  input  logic [arpc_pkg::TMO_W-1:0]      cfg_wr_data
);
  import arpc_pkg::*;

  arpc_state_t      state_r;
  arpc_state_t      state_nxt;
  logic [TMO_W-1:0] timeout_r;
  logic [SEC_W-1:0] seconds_r;
  logic             in_acc;
  arpc_cmd_t        in_cmd;
  arpc_tok_t        tok_w [0:ENTRIES];
  arpc_tok_t        fin_tok;
  arpc_res_t        fin_res;
  arpc_res_t        out_r;
  arpc_res_t        skid_r;
  logic             out_vld_r;
  logic             skid_vld_r;
  logic             take;

  assign in_cmd = arpc_cmd_t'(in_tuser);
  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = !skid_vld_r;
        if (in_tvalid && !skid_vld_r) begin
          state_nxt = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (fin_tok.vld) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      timeout_r <= TIMEOUT_RST;
      seconds_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      if (in_acc && in_cmd == CMD_TICK) begin
        seconds_r <= seconds_r + 1'b1;
      end
    end
  end

  always_comb begin
    tok_w[0].vld  = in_acc;
    tok_w[0].cmd  = in_cmd;
    tok_w[0].ip   = in_tdata[IP_W-1:0];
    tok_w[0].mac  = (in_cmd == CMD_INSERT) ? in_tdata[IP_W+MAC_W-1:IP_W] : '0;
    tok_w[0].secs = (in_cmd == CMD_TICK) ? seconds_r + 1'b1 : seconds_r;
    tok_w[0].hit  = 1'b0;
    tok_w[0].pend = (in_cmd == CMD_INSERT);
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    arpc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .timeout (timeout_r),
      .tok_i   (tok_w[i]),
      .tok_o   (tok_w[i+1])
    );
  end

  assign fin_tok = tok_w[ENTRIES];

  always_comb begin
    fin_res.hit    = (fin_tok.cmd == CMD_LOOKUP) && fin_tok.hit;
    fin_res.mac    = (fin_tok.cmd == CMD_LOOKUP) ? fin_tok.mac : '0;
    fin_res.stored = (fin_tok.cmd == CMD_INSERT) && !fin_tok.pend;
  end

  assign take = out_vld_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || take) begin
      if (skid_vld_r) begin
        out_r      <= skid_r;
        out_vld_r  <= 1'b1;
        skid_vld_r <= fin_tok.vld;
        skid_r     <= fin_res;
      end else begin
        out_vld_r <= fin_tok.vld;
        out_r     <= fin_res;
      end
    end else if (fin_tok.vld) begin
      skid_vld_r <= 1'b1;
      skid_r     <= fin_res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_DATA_W-MAC_W-2){1'b0}}, out_r.stored, out_r.mac, out_r.hit};

endmodule

// ===== design/arpc_cell.sv =====
// One cache entry cell: holds valid bit, IP, MAC and time stamp of one slot
// and hands the command token on to the next cell. Depends on arpc_pkg.
module arpc_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [arpc_pkg::TMO_W-1:0] timeout,
  input  arpc_pkg::arpc_tok_t        tok_i,
  output arpc_pkg::arpc_tok_t        tok_o
);
  import arpc_pkg::*;

  logic             valid_r;
  logic             valid_nxt;
  logic [IP_W-1:0]  ip_r;
  logic [MAC_W-1:0] mac_r;
  logic [SEC_W-1:0] stamp_r;
  logic [SEC_W-1:0] age;
  logic             wr;
  arpc_tok_t        tok_r;
  arpc_tok_t        tok_nxt;

  assign age = tok_i.secs - stamp_r;

  always_comb begin
    tok_nxt   = tok_i;
    valid_nxt = valid_r;
    wr        = 1'b0;
    if (tok_i.vld) begin
      case (tok_i.cmd)
        CMD_LOOKUP: begin
          if (valid_r && ip_r == tok_i.ip) begin
            tok_nxt.hit = 1'b1;
            tok_nxt.mac = mac_r;
          end
        end
        CMD_INSERT: begin
          if (tok_i.pend && !valid_r) begin
            wr           = 1'b1;
            valid_nxt    = 1'b1;
            tok_nxt.pend = 1'b0;
          end
        end
        CMD_TICK: begin
          if (valid_r && age > {{(SEC_W-TMO_W){1'b0}}, timeout}) begin
            valid_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      ip_r    <= tok_i.ip;
      mac_r   <= tok_i.mac;
      stamp_r <= tok_i.secs;
    end
  end

  assign tok_o = tok_r;

endmodule

// ===== design/arpc_checker.sv =====
// Port-level checks for the ARP cache table, bound to the top level.
// Depends on arpc_pkg and arp_cache_table.
module arpc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [arpc_pkg::OUT_DATA_W-1:0] out_tdata
);
  import arpc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result item dropped while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item accepted while one is in flight");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:MAC_W+2] == '0)
    else $error("padding bits of result not zero");

  a_hit_xor_stored: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[MAC_W+1]))
    else $error("hit and stored both set");

  a_miss_mac_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[MAC_W:1] == '0)
    else $error("nonzero MAC without a hit");

endmodule

bind arp_cache_table arpc_checker u_arpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== verif/arp_cache_table_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for arp_cache_table: a scoreboard class predicts every
// lookup, insert and tick result and checks the stream output item by item.
// Depends on arpc_pkg and the arp_cache_table RTL only.

module arp_cache_table_test;
  import arpc_pkg::*;

  localparam int SLOTS = ENTRIES_DEF;
  localparam int RES_W = MAC_W + 2;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 1500;
  localparam int PHASE_ITEMS = 330;
  localparam int POOL_MAX = 24;
  localparam int MAX_PRINTED = 40;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  class arp_scoreboard;
    bit [TMO_W-1:0] timeout_s;
    bit             live      [SLOTS];
    bit [IP_W-1:0]  ip_tab    [SLOTS];
    bit [MAC_W-1:0] mac_tab   [SLOTS];
    bit [SEC_W-1:0] stamp_tab [SLOTS];
    bit [SEC_W-1:0] now_s;
    arpc_res_t      pending_results [$];
    int unsigned    errors, hits, misses, stores, drops, expired;

    function void clear();
      timeout_s = TIMEOUT_RST;
      now_s = '0;
      foreach (live[i]) live[i] = 1'b0;
      pending_results.delete();
    endfunction

    function void note_input(logic [CMD_W-1:0] cmd, logic [IP_W-1:0] ip,
                             logic [MAC_W-1:0] mac);
      arpc_res_t      res;
      int             slot;
      bit [SEC_W-1:0] age;
      res = '0;
      slot = -1;
      case (cmd)
        CMD_LOOKUP: begin
          foreach (live[i]) begin
            if (live[i] && ip_tab[i] == ip) begin
              res.hit = 1'b1;
              res.mac = mac_tab[i];
            end
          end
          if (res.hit) hits++;
          else misses++;
        end
        CMD_INSERT: begin
          foreach (live[i]) begin
            if (slot < 0 && !live[i]) slot = i;
          end
          if (slot >= 0) begin
            live[slot] = 1'b1;
            ip_tab[slot] = ip;
            mac_tab[slot] = mac;
            stamp_tab[slot] = now_s;
            res.stored = 1'b1;
            stores++;
          end else begin
            drops++;
          end
        end
        CMD_TICK: begin
          now_s = now_s + 1'b1;
          foreach (live[i]) begin
            age = now_s - stamp_tab[i];
            if (live[i] && age > SEC_W'(timeout_s)) begin
              live[i] = 1'b0;
              expired++;
            end
          end
        end
        default: ;
      endcase
      pending_results.push_back(res);
    endfunction

    task report_mismatch(string what, logic [MAC_W-1:0] got, logic [MAC_W-1:0] want);
      if (errors < MAX_PRINTED)
        $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      errors++;
    endtask

    task check_result(logic [OUT_DATA_W-1:0] data);
      arpc_res_t got;
      arpc_res_t want;
      got = data[RES_W-1:0];
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing outstanding", data[MAC_W-1:0], '0);
        return;
      end
      want = pending_results.pop_front();
      if (got.hit !== want.hit)
        report_mismatch("hit", MAC_W'(got.hit), MAC_W'(want.hit));
      if (got.mac !== want.mac) report_mismatch("mac_out", got.mac, want.mac);
      if (got.stored !== want.stored)
        report_mismatch("stored", MAC_W'(got.stored), MAC_W'(want.stored));
      if (data[OUT_DATA_W-1:RES_W] !== '0)
        report_mismatch("padding", MAC_W'(data[OUT_DATA_W-1:RES_W]), '0);
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [CMD_W-1:0]      in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en;
  logic [TMO_W-1:0]      cfg_wr_data;

  arp_scoreboard sb = new();
  int unsigned   tx_idle_pct = 0;
  int unsigned   rx_stall_pct = 0;
  bit            backpressure_req = 1'b0;
  bit            backpressure_done = 1'b0;
  int unsigned   cycles = 0;
  int unsigned   items_sent = 0;
  int unsigned   settings_used = 1;
  bit [IP_W-1:0] ip_pool [$];

  arp_cache_table u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycles, sb.pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // The receiver holds off once for a long stretch so the block backs up.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (backpressure_req && !backpressure_done) begin
        backpressure_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task send_item(logic [CMD_W-1:0] cmd, logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {mac, ip};
    in_tuser <= cmd;
    do @(posedge clk); while (!in_tready);
    sb.note_input(cmd, ip, mac);
    items_sent++;
    @(negedge clk);
  endtask

  task wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task set_timeout(logic [TMO_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.timeout_s = value;
  endtask

  task set_idle(idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin tx_idle_pct <= 0;  rx_stall_pct <= 0;  end
      IDLE_SENDER:   begin tx_idle_pct <= 57; rx_stall_pct <= 0;  end
      IDLE_RECEIVER: begin tx_idle_pct <= 0;  rx_stall_pct <= 57; end
      IDLE_BOTH:     begin tx_idle_pct <= 19; rx_stall_pct <= 19; end
    endcase
  endtask

  // Addresses mostly come from a small recent pool so lookups hit and
  // inserts create duplicates.
  function automatic bit [IP_W-1:0] pick_ip(int unsigned pool_pct);
    bit [IP_W-1:0] ip;
    if (ip_pool.size() != 0 && $urandom_range(99) < pool_pct) begin
      ip = ip_pool[$urandom_range(ip_pool.size() - 1)];
    end else begin
      ip = $urandom;
      ip_pool.push_back(ip);
      if (ip_pool.size() > POOL_MAX) void'(ip_pool.pop_front());
    end
    return ip;
  endfunction

  task run_phase(logic [TMO_W-1:0] tmo, idle_mode_t mode, int unsigned ins_w,
                 int unsigned tick_w, bit pressure);
    int unsigned      roll;
    logic [CMD_W-1:0] cmd;
    bit [MAC_W-1:0]   mac;
    bit [IP_W-1:0]    ip;
    wait_drained();
    set_timeout(tmo);
    settings_used++;
    set_idle(mode);
    if (pressure) backpressure_req <= 1'b1;
    repeat (PHASE_ITEMS) begin
      roll = $urandom_range(99);
      mac = MAC_W'({$urandom, $urandom});
      if (roll < 3) begin
        cmd = CMD_SPARE;
        ip = $urandom;
      end else if (roll < 3 + tick_w) begin
        cmd = CMD_TICK;
        ip = $urandom;
      end else if (roll < 3 + tick_w + ins_w) begin
        cmd = CMD_INSERT;
        ip = pick_ip(50);
      end else begin
        cmd = CMD_LOOKUP;
        ip = pick_ip(80);
      end
      send_item(cmd, ip, mac);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    sb.clear();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed checks at the reset timeout.
    send_item(CMD_LOOKUP, '0, '0);
    send_item(CMD_INSERT, '0, '0);
    send_item(CMD_INSERT, '1, '1);
    send_item(CMD_LOOKUP, '1, '0);
    send_item(CMD_LOOKUP, '0, '1);
    send_item(CMD_INSERT, '1, 48'h1234_5678_9abc);
    send_item(CMD_LOOKUP, '1, '1);
    send_item(CMD_SPARE, '1, '1);
    send_item(CMD_LOOKUP, 32'h8000_0001, 48'h5555_aaaa_5555);
    send_item(CMD_TICK, '1, '1);
    send_item(CMD_LOOKUP, '0, '0);
    send_item(CMD_INSERT, 32'h0a00_0001, 48'h0200_0000_0001);
    send_item(CMD_LOOKUP, 32'h0a00_0001, '0);
    send_item(CMD_TICK, '0, '0);

    run_phase(16'd0,     IDLE_NONE,     40, 10, 1'b0);
    run_phase(16'hffff,  IDLE_SENDER,   60, 4,  1'b0);
    run_phase(16'd3,     IDLE_RECEIVER, 40, 15, 1'b0);
    run_phase(TMO_W'($urandom), IDLE_BOTH, 45, 8, 1'b1);
    run_phase(16'd1,     IDLE_SENDER,   45, 12, 1'b0);
    run_phase(16'd15,    IDLE_BOTH,     55, 6,  1'b0);

    wait_drained();
    repeat (2 * SLOTS + 10) @(negedge clk);

    $display("Sent %0d items across %0d timeout settings and four idle patterns.",
             items_sent, settings_used);
    $display("Lookups %0d hit / %0d missed; inserts %0d stored / %0d dropped full; %0d aged out.",
             sb.hits, sb.misses, sb.stores, sb.drops, sb.expired);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/arpc_pkg.sv
design/arpc_cell.sv
design/arp_cache_table.sv
design/arpc_checker.sv
verif/arp_cache_table_test.sv
